// ----- rtl/core/cpt_pkg.sv -----
// ----------------------------------------------------------------------------
// Closest point on triangle: shared types and constants
// Default widths, region codes and the ratio unit's result kinds and depth.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int CoordWidth = 24;
  localparam int FracBits   = 16;
  // Width of the numerator and divisor of a face or edge parameter
  localparam int RatioWidth = 4 * CoordWidth + 11;

  typedef enum logic [2:0] {
    RegVertA  = 3'd0,
    RegVertB  = 3'd1,
    RegEdgeAb = 3'd2,
    RegVertC  = 3'd3,
    RegEdgeAc = 3'd4,
    RegEdgeBc = 3'd5,
    RegFace   = 3'd6
  } region_e;

  typedef enum logic [1:0] {
    RatioZero,
    RatioOne,
    RatioDiv
  } ratio_kind_e;

  // Register stages of the ratio unit: sign fix, classify, one per quotient bit
  // but the last, output
  function automatic int ratio_lat(input int frac_bits);
    return frac_bits + 3;
  endfunction

endpackage

// ----- rtl/core/cpt_ratio.sv -----
// ----------------------------------------------------------------------------
// Closest point on triangle: pipelined ratio unit
// Forms num/den as an unsigned fraction with FRAC_BITS fraction bits, saturated to
// [0, 1.0], zero for a zero divisor; one quotient bit per stage, rounded half up.
// ----------------------------------------------------------------------------
module cpt_ratio #(
  parameter int NUM_WIDTH = cpt_pkg::RatioWidth,
  parameter int FRAC_BITS = cpt_pkg::FracBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [NUM_WIDTH-1:0] num_i,
  input  logic signed [NUM_WIDTH-1:0] den_i,
  output logic                        valid_o,
  output logic        [FRAC_BITS:0]   ratio_o
);

  localparam int N  = NUM_WIDTH + 1;
  localparam int FB = FRAC_BITS;

  // Stage A: make the divisor positive
  logic signed [N-1:0] a_num_d, a_den_d, a_num_q, a_den_q;
  logic                a_zero_q, a_valid_q;

  always_comb begin
    a_num_d = N'(num_i);
    a_den_d = N'(den_i);
    if (den_i[NUM_WIDTH-1]) begin
      a_num_d = -a_num_d;
      a_den_d = -a_den_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_num_q  <= a_num_d;
    a_den_q  <= a_den_d;
    a_zero_q <= (den_i == '0);
  end

  // Stage B: classify saturated cases
  cpt_pkg::ratio_kind_e b_kind_d, b_kind_q;
  logic [N-1:0]         b_rem_q, b_den_q;
  logic                 b_valid_q;

  always_comb begin
    priority if (a_zero_q) begin
      b_kind_d = cpt_pkg::RatioZero;
    end else if (a_num_q <= 0) begin
      b_kind_d = cpt_pkg::RatioZero;
    end else if (a_num_q >= a_den_q) begin
      b_kind_d = cpt_pkg::RatioOne;
    end else begin
      b_kind_d = cpt_pkg::RatioDiv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_kind_q <= b_kind_d;
    b_rem_q  <= a_num_q;
    b_den_q  <= a_den_q;
  end

  // Restoring division, one quotient bit per stage
  logic [N-1:0]         it_rem_q   [FB];
  logic [N-1:0]         it_den_q   [FB];
  logic [FB:0]          it_quo_q   [FB];
  cpt_pkg::ratio_kind_e it_kind_q  [FB];
  logic                 it_valid_q [FB];

  for (genvar k = 0; k < FB; k++) begin : g_iter
    logic [N-1:0]         rem_in, den_in;
    logic [FB:0]          quo_in;
    cpt_pkg::ratio_kind_e kind_in;
    logic                 valid_in;
    logic [N:0]           rem2, diff;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_in   = b_rem_q;
      assign den_in   = b_den_q;
      assign quo_in   = '0;
      assign kind_in  = b_kind_q;
      assign valid_in = b_valid_q;
    end else begin : g_next
      assign rem_in   = it_rem_q[k-1];
      assign den_in   = it_den_q[k-1];
      assign quo_in   = it_quo_q[k-1];
      assign kind_in  = it_kind_q[k-1];
      assign valid_in = it_valid_q[k-1];
    end

    assign rem2 = {rem_in, 1'b0};
    assign diff = rem2 - {1'b0, den_in};
    assign ge   = ~diff[N];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        it_valid_q[k] <= 1'b0;
      end else begin
        it_valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      it_rem_q[k]  <= ge ? diff[N-1:0] : rem2[N-1:0];
      it_den_q[k]  <= den_in;
      it_quo_q[k]  <= {quo_in[FB-1:0], ge};
      it_kind_q[k] <= kind_in;
    end
  end

  // Output stage: last quotient bit, round half up, select saturated values
  logic [N:0]    last_rem2, last_diff;
  logic [FB:0]   last_quo;
  logic [FB+1:0] quo_inc;
  logic [FB:0]   ratio_d;

  always_comb begin
    last_rem2 = {it_rem_q[FB-1], 1'b0};
    last_diff = last_rem2 - {1'b0, it_den_q[FB-1]};
    last_quo  = {it_quo_q[FB-1][FB-1:0], ~last_diff[N]};
    quo_inc   = (FB+2)'(last_quo) + (FB+2)'(1);
    unique case (it_kind_q[FB-1])
      cpt_pkg::RatioOne: ratio_d = {1'b1, {FB{1'b0}}};
      cpt_pkg::RatioDiv: ratio_d = quo_inc[FB+1:1];
      default:           ratio_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= it_valid_q[FB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ratio_o <= ratio_d;
  end

endmodule

// ----- rtl/core/closest_point_on_triangle_core.sv -----
// ----------------------------------------------------------------------------
// Closest point on triangle core
// Voronoi-region closest point of a query to a triangle, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   An item (query point and vertices a, b, c, signed Q8.16) is taken at each
//   rising edge with start high and busy low. busy is always low: a new
//   triangle may enter in every cycle.
//   Each item yields one result, shown for one cycle with done_o high:
//   closest point, barycentric weights (Q1.16), squared distance (Q18.32)
//   and region code. Results leave in the order the items came in.
//   The pipeline has seven stages for differences, dot products, split
//   cross products and the region choice, FRAC_BITS + 3 stages of the
//   bit-per-stage dividers, and four stages for the point product,
//   rounding, squaring and the distance sum.
//   Throughput is one item per cycle.
//   Reset clears all valid bits; items in flight are dropped.
//   The receiver cannot stall the block and no back-pressure exists.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_core #(
  parameter int COORD_WIDTH = cpt_pkg::CoordWidth,
  parameter int FRAC_BITS   = cpt_pkg::FracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] query_x_i,
  input  logic signed [COORD_WIDTH-1:0] query_y_i,
  input  logic signed [COORD_WIDTH-1:0] query_z_i,
  input  logic signed [COORD_WIDTH-1:0] vert_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] vert_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] vert_a_z_i,
  input  logic signed [COORD_WIDTH-1:0] vert_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] vert_b_y_i,
  input  logic signed [COORD_WIDTH-1:0] vert_b_z_i,
  input  logic signed [COORD_WIDTH-1:0] vert_c_x_i,
  input  logic signed [COORD_WIDTH-1:0] vert_c_y_i,
  input  logic signed [COORD_WIDTH-1:0] vert_c_z_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] closest_x_o,
  output logic signed [COORD_WIDTH-1:0] closest_y_o,
  output logic signed [COORD_WIDTH-1:0] closest_z_o,
  output logic        [FRAC_BITS:0]     weight_a_o,
  output logic        [FRAC_BITS:0]     weight_b_o,
  output logic        [FRAC_BITS:0]     weight_c_o,
  output logic        [2*COORD_WIDTH+1:0] dist_squared_o,
  output logic        [2:0]             region_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int DW   = CW + 1;          // coordinate difference
  localparam int PW   = 2 * DW;          // difference product
  localparam int DDW  = PW + 2;          // dot product
  localparam int HL   = (DDW + 1) / 2;   // low half of a split dot product
  localparam int HH   = DDW - HL;        // high half
  localparam int CPW  = 2 * DDW;         // product of two dot products
  localparam int VW   = CPW + 1;         // barycentric numerator
  localparam int RW   = CPW + 3;         // ratio operand
  localparam int MW   = DW + FB + 2;     // direction times parameter
  localparam int SW   = MW - FB + 2;     // rounded point before saturation
  localparam int QW   = 2 * CW + 2;      // squared distance
  localparam int RLAT = cpt_pkg::ratio_lat(FB);
  localparam int NS   = 7;               // stages ahead of the dividers

  localparam int CrossX [6] = '{0, 2, 4, 0, 2, 4};
  localparam int CrossY [6] = '{3, 1, 1, 5, 5, 3};
  localparam logic [FB:0] One  = {1'b1, {FB{1'b0}}};
  localparam logic [MW:0] Half = (MW+1)'(1) << (FB - 1);

  typedef struct packed {
    logic [2:0][CW-1:0] p;
    logic [2:0][CW-1:0] a;
    logic [2:0][CW-1:0] b;
    logic [2:0][CW-1:0] c;
  } geom_t;

  typedef struct packed {
    geom_t              g;
    cpt_pkg::region_e   r;
  } tag_t;

  logic  accept;
  geom_t in_geom;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_comb begin
    in_geom.p = {query_z_i, query_y_i, query_x_i};
    in_geom.a = {vert_a_z_i, vert_a_y_i, vert_a_x_i};
    in_geom.b = {vert_b_z_i, vert_b_y_i, vert_b_x_i};
    in_geom.c = {vert_c_z_i, vert_c_y_i, vert_c_x_i};
  end

  // Valid bits and geometry for the stages ahead of the dividers
  logic  vld_q  [NS];
  geom_t geom_q [NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept;
      for (int k = 1; k < NS; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    geom_q[0] <= in_geom;
    for (int k = 1; k < NS; k++) begin
      geom_q[k] <= geom_q[k-1];
    end
  end

  // Stage 1: edge and query differences
  logic signed [DW-1:0] ab_d [3], ac_d [3], ap_d [3], bp_d [3], cp_d [3];
  logic signed [DW-1:0] ab_q [3], ac_q [3], ap_q [3], bp_q [3], cp_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ap_d[i] = DW'($signed(in_geom.p[i])) - DW'($signed(in_geom.a[i]));
      bp_d[i] = DW'($signed(in_geom.p[i])) - DW'($signed(in_geom.b[i]));
      cp_d[i] = DW'($signed(in_geom.p[i])) - DW'($signed(in_geom.c[i]));
      ab_d[i] = DW'($signed(in_geom.b[i])) - DW'($signed(in_geom.a[i]));
      ac_d[i] = DW'($signed(in_geom.c[i])) - DW'($signed(in_geom.a[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    ab_q <= ab_d;
    ac_q <= ac_d;
    ap_q <= ap_d;
    bp_q <= bp_d;
    cp_q <= cp_d;
  end

  // Stage 2: per-axis products of the six dot products
  logic signed [PW-1:0] prod_d [6][3], prod_q [6][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[0][i] = ab_q[i] * ap_q[i];
      prod_d[1][i] = ac_q[i] * ap_q[i];
      prod_d[2][i] = ab_q[i] * bp_q[i];
      prod_d[3][i] = ac_q[i] * bp_q[i];
      prod_d[4][i] = ab_q[i] * cp_q[i];
      prod_d[5][i] = ac_q[i] * cp_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Stage 3: sum into d1..d6
  logic signed [DDW-1:0] dot_d [6], dot_q [6];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      dot_d[j] = DDW'(prod_q[j][0]) + DDW'(prod_q[j][1]) + DDW'(prod_q[j][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    dot_q <= dot_d;
  end

  // Stage 4: split cross products into four partial products each
  logic        [2*HL-1:0]   pll_d [6], pll_q [6];
  logic signed [HL+HH:0]    plh_d [6], plh_q [6];
  logic signed [HL+HH:0]    phl_d [6], phl_q [6];
  logic signed [2*HH-1:0]   phh_d [6], phh_q [6];
  logic signed [DDW-1:0]    dot4_q [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      pll_d[k] = dot_q[CrossX[k]][HL-1:0] * dot_q[CrossY[k]][HL-1:0];
      plh_d[k] = $signed({1'b0, dot_q[CrossX[k]][HL-1:0]})
               * $signed(dot_q[CrossY[k]][DDW-1:HL]);
      phl_d[k] = $signed(dot_q[CrossX[k]][DDW-1:HL])
               * $signed({1'b0, dot_q[CrossY[k]][HL-1:0]});
      phh_d[k] = $signed(dot_q[CrossX[k]][DDW-1:HL])
               * $signed(dot_q[CrossY[k]][DDW-1:HL]);
    end
  end

  always_ff @(posedge clk_i) begin
    pll_q  <= pll_d;
    plh_q  <= plh_d;
    phl_q  <= phl_d;
    phh_q  <= phh_d;
    dot4_q <= dot_q;
  end

  // Stage 5: combine partial products
  logic signed [CPW-1:0] cross_d [6], cross_q [6];
  logic signed [DDW-1:0] dot5_q  [6];

  always_comb begin
    logic signed [CPW-1:0] ll_e, lh_e, hl_e, hh_e;
    for (int k = 0; k < 6; k++) begin
      ll_e = CPW'(pll_q[k]);
      lh_e = CPW'(plh_q[k]);
      hl_e = CPW'(phl_q[k]);
      hh_e = CPW'(phh_q[k]);
      cross_d[k] = (hh_e <<< (2 * HL)) + ((lh_e + hl_e) <<< HL) + ll_e;
    end
  end

  always_ff @(posedge clk_i) begin
    cross_q <= cross_d;
    dot5_q  <= dot4_q;
  end

  // Stage 6: barycentric numerators
  logic signed [VW-1:0]  va_q, vb_q, vc_q;
  logic signed [DDW-1:0] dot6_q [6];

  always_ff @(posedge clk_i) begin
    vc_q   <= VW'(cross_q[0]) - VW'(cross_q[1]);
    vb_q   <= VW'(cross_q[2]) - VW'(cross_q[3]);
    va_q   <= VW'(cross_q[4]) - VW'(cross_q[5]);
    dot6_q <= dot5_q;
  end

  // Stage 7: choose the region and the divider operands
  cpt_pkg::region_e     region_d, region7_q;
  logic signed [RW-1:0] num0_d, den0_d, num1_d, den1_d;
  logic signed [RW-1:0] num0_q, den0_q, num1_q, den1_q;
  logic signed [DDW:0]  e13, e26, e43, e56;

  always_comb begin
    e13 = (DDW+1)'(dot6_q[0]) - (DDW+1)'(dot6_q[2]);
    e26 = (DDW+1)'(dot6_q[1]) - (DDW+1)'(dot6_q[5]);
    e43 = (DDW+1)'(dot6_q[3]) - (DDW+1)'(dot6_q[2]);
    e56 = (DDW+1)'(dot6_q[4]) - (DDW+1)'(dot6_q[5]);
    num0_d = '0;
    den0_d = '0;
    num1_d = '0;
    den1_d = '0;
    priority if (dot6_q[0] <= 0 && dot6_q[1] <= 0) begin
      region_d = cpt_pkg::RegVertA;
    end else if (dot6_q[2] >= 0 && dot6_q[3] <= dot6_q[2]) begin
      region_d = cpt_pkg::RegVertB;
    end else if (vc_q <= 0 && dot6_q[0] >= 0 && dot6_q[2] <= 0) begin
      region_d = cpt_pkg::RegEdgeAb;
      num0_d   = RW'(dot6_q[0]);
      den0_d   = RW'(e13);
    end else if (dot6_q[5] >= 0 && dot6_q[4] <= dot6_q[5]) begin
      region_d = cpt_pkg::RegVertC;
    end else if (vb_q <= 0 && dot6_q[1] >= 0 && dot6_q[5] <= 0) begin
      region_d = cpt_pkg::RegEdgeAc;
      num0_d   = RW'(dot6_q[1]);
      den0_d   = RW'(e26);
    end else if (va_q <= 0 && e43 >= 0 && e56 >= 0) begin
      region_d = cpt_pkg::RegEdgeBc;
      num0_d   = RW'(e43);
      den0_d   = RW'(e43) + RW'(e56);
    end else begin
      region_d = cpt_pkg::RegFace;
      num0_d   = RW'(vb_q);
      num1_d   = RW'(vc_q);
      den0_d   = RW'(va_q) + RW'(vb_q) + RW'(vc_q);
      den1_d   = den0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    region7_q <= region_d;
    num0_q    <= num0_d;
    den0_q    <= den0_d;
    num1_q    <= num1_d;
    den1_q    <= den1_d;
  end

  // Dividers; the second one serves only the face
  logic          r0_valid, r1_valid;
  logic [FB:0]   t0, t1;

  cpt_ratio #(
    .NUM_WIDTH (RW),
    .FRAC_BITS (FB)
  ) u_ratio0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[NS-1]),
    .num_i   (num0_q),
    .den_i   (den0_q),
    .valid_o (r0_valid),
    .ratio_o (t0)
  );

  cpt_ratio #(
    .NUM_WIDTH (RW),
    .FRAC_BITS (FB)
  ) u_ratio1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[NS-1]),
    .num_i   (num1_q),
    .den_i   (den1_q),
    .valid_o (r1_valid),
    .ratio_o (t1)
  );

  // Hold geometry and region alongside the dividers
  tag_t tag_q [RLAT];

  always_ff @(posedge clk_i) begin
    tag_q[0] <= '{g: geom_q[NS-1], r: region7_q};
    for (int k = 1; k < RLAT; k++) begin
      tag_q[k] <= tag_q[k-1];
    end
  end

  // Stage 8: weights and direction products
  geom_t                tg;
  cpt_pkg::region_e     tr;
  logic signed [DW-1:0] dir1 [3], dir2 [3];
  logic signed [CW-1:0] base_d [3], base_q [3];
  logic signed [MW-1:0] m1_d [3], m2_d [3], m1_q [3], m2_q [3];
  logic        [FB:0]   wa_d, wb_d, wc_d;
  logic        [FB+2:0] wsum;
  logic                 s8_vld_q;
  logic        [FB:0]   wa8_q, wb8_q, wc8_q;
  cpt_pkg::region_e     r8_q;
  logic [2:0][CW-1:0]   p8_q;

  assign tg = tag_q[RLAT-1].g;
  assign tr = tag_q[RLAT-1].r;

  always_comb begin
    wsum = (FB+3)'(One) - (FB+3)'(t0) - (FB+3)'(t1);
    for (int i = 0; i < 3; i++) begin
      dir1[i]   = '0;
      dir2[i]   = '0;
      base_d[i] = $signed(tg.a[i]);
    end
    wa_d = '0;
    wb_d = '0;
    wc_d = '0;
    unique case (tr)
      cpt_pkg::RegVertB: begin
        for (int i = 0; i < 3; i++) base_d[i] = $signed(tg.b[i]);
        wb_d = One;
      end
      cpt_pkg::RegVertC: begin
        for (int i = 0; i < 3; i++) base_d[i] = $signed(tg.c[i]);
        wc_d = One;
      end
      cpt_pkg::RegEdgeAb: begin
        for (int i = 0; i < 3; i++) begin
          dir1[i] = DW'($signed(tg.b[i])) - DW'($signed(tg.a[i]));
        end
        wa_d = One - t0;
        wb_d = t0;
      end
      cpt_pkg::RegEdgeAc: begin
        for (int i = 0; i < 3; i++) begin
          dir1[i] = DW'($signed(tg.c[i])) - DW'($signed(tg.a[i]));
        end
        wa_d = One - t0;
        wc_d = t0;
      end
      cpt_pkg::RegEdgeBc: begin
        for (int i = 0; i < 3; i++) begin
          base_d[i] = $signed(tg.b[i]);
          dir1[i]   = DW'($signed(tg.c[i])) - DW'($signed(tg.b[i]));
        end
        wb_d = One - t0;
        wc_d = t0;
      end
      cpt_pkg::RegFace: begin
        for (int i = 0; i < 3; i++) begin
          dir1[i] = DW'($signed(tg.b[i])) - DW'($signed(tg.a[i]));
          dir2[i] = DW'($signed(tg.c[i])) - DW'($signed(tg.a[i]));
        end
        wa_d = wsum[FB+2] ? '0 : wsum[FB:0];
        wb_d = t0;
        wc_d = t1;
      end
      default: begin
        wa_d = One;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      m1_d[i] = dir1[i] * $signed({1'b0, t0});
      m2_d[i] = dir2[i] * $signed({1'b0, t1});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
    end else begin
      s8_vld_q <= r0_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q   <= m1_d;
    m2_q   <= m2_d;
    base_q <= base_d;
    wa8_q  <= wa_d;
    wb8_q  <= wb_d;
    wc8_q  <= wc_d;
    r8_q   <= tr;
    p8_q   <= tg.p;
  end

  // Stage 9: round, add the base vertex, saturate
  logic signed [MW:0]   sm;
  logic signed [SW-1:0] sp;
  logic signed [CW-1:0] cl_d [3], cl9_q [3];
  logic                 s9_vld_q;
  logic        [FB:0]   wa9_q, wb9_q, wc9_q;
  cpt_pkg::region_e     r9_q;
  logic [2:0][CW-1:0]   p9_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sm = (MW+1)'(m1_q[i]) + (MW+1)'(m2_q[i]) + Half;
      sp = SW'($signed(sm[MW:FB])) + SW'(base_q[i]);
      if (&sp[SW-1:CW-1] || ~|sp[SW-1:CW-1]) begin
        cl_d[i] = sp[CW-1:0];
      end else begin
        cl_d[i] = {sp[SW-1], {(CW-1){~sp[SW-1]}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_vld_q <= 1'b0;
    end else begin
      s9_vld_q <= s8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cl9_q <= cl_d;
    wa9_q <= wa8_q;
    wb9_q <= wb8_q;
    wc9_q <= wc8_q;
    r9_q  <= r8_q;
    p9_q  <= p8_q;
  end

  // Stage 10: squared axis distances
  logic signed [CW:0]   dd;
  logic signed [QW-1:0] sq_d [3], sq_q [3];
  logic signed [CW-1:0] cl10_q [3];
  logic                 s10_vld_q;
  logic        [FB:0]   wa10_q, wb10_q, wc10_q;
  cpt_pkg::region_e     r10_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd      = (CW+1)'(cl9_q[i]) - (CW+1)'($signed(p9_q[i]));
      sq_d[i] = dd * dd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s10_vld_q <= 1'b0;
    end else begin
      s10_vld_q <= s9_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    cl10_q <= cl9_q;
    wa10_q <= wa9_q;
    wb10_q <= wb9_q;
    wc10_q <= wc9_q;
    r10_q  <= r9_q;
  end

  // Output stage: distance sum and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= s10_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    closest_x_o    <= cl10_q[0];
    closest_y_o    <= cl10_q[1];
    closest_z_o    <= cl10_q[2];
    weight_a_o     <= wa10_q;
    weight_b_o     <= wb10_q;
    weight_c_o     <= wc10_q;
    dist_squared_o <= sq_q[0] + sq_q[1] + sq_q[2];
    region_o       <= r10_q;
  end

`ifndef SYNTHESIS
  // Both dividers see the same items
  a_ratio_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    r0_valid == r1_valid)
    else $error("divider valid bits out of step");

  // Vertex regions get a zero edge parameter
  a_vertex_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    r0_valid && (tr == cpt_pkg::RegVertA || tr == cpt_pkg::RegVertB ||
                 tr == cpt_pkg::RegVertC) |-> t0 == '0)
    else $error("nonzero parameter in a vertex region");

  // Only the face uses the second divider
  a_face_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    r1_valid && tr != cpt_pkg::RegFace |-> t1 == '0)
    else $error("second parameter set outside the face");

  // Edge ab weights split 1.0 between a and b
  a_edge_ab_weights : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && region_o == cpt_pkg::RegEdgeAb |->
      ((FB+2)'(weight_a_o) + (FB+2)'(weight_b_o) == (FB+2)'(One)) &&
      weight_c_o == '0)
    else $error("edge ab weights do not sum to one");
`endif

endmodule

// ----- tb/closest_point_on_triangle_core_tb.sv -----
// ----------------------------------------------------------------------------
// Closest point on triangle core testbench
// Feeds query points and triangles through the pipelined core, with random
// gaps between transactions. Every result is checked against a local
// fixed-point model of the Voronoi-region closest point search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module closest_point_on_triangle_core_tb;

  localparam int CW        = cpt_pkg::CoordWidth;
  localparam int FB        = cpt_pkg::FracBits;
  localparam int NumRandom = 1330;
  localparam int Drain     = FB + 30;
  localparam int CycleLimit = 200000;
  localparam longint OneQ  = longint'(1) << FB;
  localparam longint CMax  = (longint'(1) << (CW - 1)) - 1;
  localparam longint CMin  = -(longint'(1) << (CW - 1));

  typedef logic signed [127:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_query_t;

  typedef struct packed {
    coord_t         cl_x, cl_y, cl_z;
    logic [FB:0]    w_a, w_b, w_c;
    logic [2*CW+1:0] dist_sq;
    logic [2:0]     region;
  } tri_hit_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  tri_query_t drv_q = '0;
  tri_hit_t   got;
  logic       done_o;

  tri_query_t query_fifo[$];
  tri_hit_t   hit_fifo[$];
  int         n_sent, n_checked, n_errors, cycles;
  int         region_hits[8];
  logic [3:0] gap_cnt = '0;
  logic       burst = 1'b0;

  closest_point_on_triangle_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .query_x_i     (drv_q.px),
    .query_y_i     (drv_q.py),
    .query_z_i     (drv_q.pz),
    .vert_a_x_i    (drv_q.ax),
    .vert_a_y_i    (drv_q.ay),
    .vert_a_z_i    (drv_q.az),
    .vert_b_x_i    (drv_q.bx),
    .vert_b_y_i    (drv_q.by),
    .vert_b_z_i    (drv_q.bz),
    .vert_c_x_i    (drv_q.cx),
    .vert_c_y_i    (drv_q.cy),
    .vert_c_z_i    (drv_q.cz),
    .done_o        (done_o),
    .closest_x_o   (got.cl_x),
    .closest_y_o   (got.cl_y),
    .closest_z_o   (got.cl_z),
    .weight_a_o    (got.w_a),
    .weight_b_o    (got.w_b),
    .weight_c_o    (got.w_c),
    .dist_squared_o(got.dist_sq),
    .region_o      (got.region)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic wide_t widen(longint x);
    wide_t r;
    r = x;
    return r;
  endfunction

  // Q1.16 fraction num/den, saturated to [0, 1.0], zero on a zero divisor
  function automatic longint frac_q(wide_t num, wide_t den);
    longint q;
    q = 0;
    if (den == 0) return 0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return 0;
    if (num >= den) return OneQ;
    for (int i = 0; i <= FB; i++) begin
      num = num <<< 1;
      q = q << 1;
      if (num >= den) begin
        num = num - den;
        q = q | 1;
      end
    end
    return (q + 1) >>> 1;
  endfunction

  // Round half up out of Q.16
  function automatic longint rnd_q(longint x);
    return (x + (OneQ >>> 1)) >>> FB;
  endfunction

  function automatic tri_hit_t closest_on_tri(tri_query_t t);
    longint p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3], cl[3];
    longint d1, d2, d3, d4, d5, d6, wa, wb, wc, s, s2, dd, dsum;
    wide_t va, vb, vc, den;
    cpt_pkg::region_e reg_id;
    tri_hit_t r;
    p = '{t.px, t.py, t.pz};
    a = '{t.ax, t.ay, t.az};
    b = '{t.bx, t.by, t.bz};
    c = '{t.cx, t.cy, t.cz};
    for (int i = 0; i < 3; i++) begin
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      ap[i] = p[i] - a[i];
      bp[i] = p[i] - b[i];
      cp[i] = p[i] - c[i];
    end
    d1 = ab[0]*ap[0] + ab[1]*ap[1] + ab[2]*ap[2];
    d2 = ac[0]*ap[0] + ac[1]*ap[1] + ac[2]*ap[2];
    d3 = ab[0]*bp[0] + ab[1]*bp[1] + ab[2]*bp[2];
    d4 = ac[0]*bp[0] + ac[1]*bp[1] + ac[2]*bp[2];
    d5 = ab[0]*cp[0] + ab[1]*cp[1] + ab[2]*cp[2];
    d6 = ac[0]*cp[0] + ac[1]*cp[1] + ac[2]*cp[2];
    vc = widen(d1) * widen(d4) - widen(d3) * widen(d2);
    vb = widen(d5) * widen(d2) - widen(d1) * widen(d6);
    va = widen(d3) * widen(d6) - widen(d5) * widen(d4);

    // Pick the region in priority order
    if (d1 <= 0 && d2 <= 0) begin
      reg_id = cpt_pkg::RegVertA; wa = OneQ; wb = 0; wc = 0; cl = a;
    end else if (d3 >= 0 && d4 <= d3) begin
      reg_id = cpt_pkg::RegVertB; wa = 0; wb = OneQ; wc = 0; cl = b;
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      reg_id = cpt_pkg::RegEdgeAb;
      s = frac_q(widen(d1), widen(d1 - d3));
      wa = OneQ - s; wb = s; wc = 0;
      for (int i = 0; i < 3; i++) cl[i] = a[i] + rnd_q(ab[i] * s);
    end else if (d6 >= 0 && d5 <= d6) begin
      reg_id = cpt_pkg::RegVertC; wa = 0; wb = 0; wc = OneQ; cl = c;
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      reg_id = cpt_pkg::RegEdgeAc;
      s = frac_q(widen(d2), widen(d2 - d6));
      wa = OneQ - s; wb = 0; wc = s;
      for (int i = 0; i < 3; i++) cl[i] = a[i] + rnd_q(ac[i] * s);
    end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
      reg_id = cpt_pkg::RegEdgeBc;
      s = frac_q(widen(d4 - d3), widen((d4 - d3) + (d5 - d6)));
      wa = 0; wb = OneQ - s; wc = s;
      for (int i = 0; i < 3; i++) cl[i] = b[i] + rnd_q((c[i] - b[i]) * s);
    end else begin
      reg_id = cpt_pkg::RegFace;
      den = va + vb + vc;
      s = frac_q(vb, den);
      s2 = frac_q(vc, den);
      wa = OneQ - s - s2;
      if (wa < 0) wa = 0;
      wb = s; wc = s2;
      for (int i = 0; i < 3; i++) cl[i] = a[i] + rnd_q(ab[i] * s + ac[i] * s2);
    end

    // Saturate the point and sum the squared distance
    dsum = 0;
    for (int i = 0; i < 3; i++) begin
      if (cl[i] > CMax) cl[i] = CMax;
      if (cl[i] < CMin) cl[i] = CMin;
      dd = cl[i] - p[i];
      dsum += dd * dd;
    end
    r.cl_x = coord_t'(cl[0]);
    r.cl_y = coord_t'(cl[1]);
    r.cl_z = coord_t'(cl[2]);
    r.w_a = wa[FB:0];
    r.w_b = wb[FB:0];
    r.w_c = wc[FB:0];
    r.dist_sq = dsum[2*CW+1:0];
    r.region = reg_id;
    return r;
  endfunction

  function automatic coord_t rnd_near(longint ctr, int span);
    longint v;
    v = ctr + longint'($urandom_range(0, 2 * span)) - span;
    if (v > CMax) v = CMax;
    if (v < CMin) v = CMin;
    return coord_t'(v);
  endfunction

  // Random triangle: full range, clustered, or degenerate
  function automatic tri_query_t rand_query();
    tri_query_t t;
    int span, mode;
    longint org;
    mode = $urandom_range(0, 9);
    span = 1 << $urandom_range(2, CW - 2);
    org = longint'($signed($urandom_range(0, (1 << CW) - 1) << (32 - CW))) >>> (32 - CW);
    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom};
    if (mode >= 2) begin
      t.ax = rnd_near(org, span); t.ay = rnd_near(org, span); t.az = rnd_near(org, span);
      t.bx = rnd_near(org, span); t.by = rnd_near(org, span); t.bz = rnd_near(org, span);
      t.cx = rnd_near(org, span); t.cy = rnd_near(org, span); t.cz = rnd_near(org, span);
      t.px = rnd_near(org, span); t.py = rnd_near(org, span); t.pz = rnd_near(org, span);
      if (mode == 2) begin
        t.bx = t.ax; t.by = t.ay; t.bz = t.az;
      end else if (mode == 3) begin
        t.cx = t.bx; t.cy = t.by; t.cz = t.bz;
      end else if (mode == 4) begin
        t.cx = t.ax; t.cy = t.ay; t.cz = t.az;
      end
    end
    return t;
  endfunction

  function automatic tri_query_t unit_tri(coord_t qx, coord_t qy, coord_t qz);
    tri_query_t t;
    t = '0;
    t.bx = coord_t'(OneQ);
    t.cy = coord_t'(OneQ);
    t.px = qx; t.py = qy; t.pz = qz;
    return t;
  endfunction

  // Driver: present one transaction, then hold off for a drawn gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start   <= 1'b0;
      gap_cnt <= '0;
    end else begin
      if (start && !busy) begin
        hit_fifo.push_back(closest_on_tri(drv_q));
        n_sent++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_cnt != 0) begin
        gap_cnt <= gap_cnt - 1'b1;
        start   <= 1'b0;
      end else if (query_fifo.size() > 0) begin
        drv_q <= query_fifo.pop_front();
        start <= 1'b1;
        if ($urandom_range(0, 63) == 0) burst <= ~burst;
        gap_cnt <= burst ? 4'd0 : 4'($urandom_range(0, 15));
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each result against the oldest prediction
  always @(posedge clk_i) begin
    tri_hit_t want;
    if (rst_ni && done_o) begin
      if (hit_fifo.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result %p", got);
      end else begin
        want = hit_fifo.pop_front();
        n_checked++;
        region_hits[want.region]++;
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result %0d mismatch\n  exp %p\n  got %p", n_checked, want, got);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    tri_query_t t;
    // Directed: each region on a unit triangle, extremes, degenerate shapes
    query_fifo.push_back(unit_tri(-24'sd65536, -24'sd65536, 24'sd0));
    query_fifo.push_back(unit_tri(24'sd131072, -24'sd32768, 24'sd0));
    query_fifo.push_back(unit_tri(24'sd32768, -24'sd65536, 24'sd0));
    query_fifo.push_back(unit_tri(-24'sd32768, 24'sd131072, 24'sd0));
    query_fifo.push_back(unit_tri(-24'sd65536, 24'sd32768, 24'sd0));
    query_fifo.push_back(unit_tri(24'sd65536, 24'sd65536, 24'sd0));
    query_fifo.push_back(unit_tri(24'sd16384, 24'sd16384, 24'sd65536));
    query_fifo.push_back(unit_tri(24'sd21845, 24'sd21845, -24'sd100));
    query_fifo.push_back(unit_tri(24'sd1, 24'sd1, 24'sd0));
    query_fifo.push_back('0);
    query_fifo.push_back({12{coord_t'(CMax)}});
    query_fifo.push_back({12{coord_t'(CMin)}});
    t = '0;
    t.ax = coord_t'(CMin); t.by = coord_t'(CMax); t.cz = coord_t'(CMin);
    t.px = coord_t'(CMax); t.py = coord_t'(CMin); t.pz = coord_t'(CMax);
    query_fifo.push_back(t);
    t.ax = coord_t'(CMax); t.ay = coord_t'(CMin); t.bx = coord_t'(CMin);
    t.cy = coord_t'(CMax); t.px = '0; t.py = '0; t.pz = '0;
    query_fifo.push_back(t);
    // Collinear vertices and a point-sized triangle
    t = '0;
    t.bx = 24'sd65536; t.cx = 24'sd131072; t.px = 24'sd70000; t.py = 24'sd5000;
    query_fifo.push_back(t);
    t = '0;
    t.ax = 24'sd300; t.bx = 24'sd300; t.cx = 24'sd300; t.py = 24'sd77;
    query_fifo.push_back(t);
    t = '0;
    t.cx = 24'sd65536; t.px = 24'sd30000; t.py = 24'sd9;
    query_fifo.push_back(t);
    for (int i = 0; i < NumRandom; i++) query_fifo.push_back(rand_query());

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(query_fifo.size() == 0 && !start && hit_fifo.size() == 0))
      @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);

    $display("Sent %0d triangles, checked %0d results", n_sent, n_checked);
    $display("Regions A %0d, B %0d, AB %0d, C %0d, AC %0d, BC %0d, face %0d",
             region_hits[0], region_hits[1], region_hits[2], region_hits[3],
             region_hits[4], region_hits[5], region_hits[6]);
    if (n_errors == 0 && hit_fifo.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Mismatches: %0d", n_errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/cpt_pkg.sv
rtl/core/cpt_ratio.sv
rtl/core/closest_point_on_triangle_core.sv
tb/closest_point_on_triangle_core_tb.sv
